[hw/rtl/mfp_pkg.sv]
package mfp_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int IDX_W = $clog2(MAX_PAYLOAD);
	localparam int LEN_W = 7;

	localparam logic [7:0] SYM_START = 8'h24;
	localparam logic [7:0] SYM_M     = 8'h4D;
	localparam logic [7:0] SYM_LT    = 8'h3C;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd64;

	typedef enum logic [2:0] {
		ST_START,
		ST_M,
		ST_ARROW,
		ST_LEN,
		ST_CMD,
		ST_DATA,
		ST_CSUM,
		ST_EMIT
	} mfp_state_t;

	// controller -> datapath
	typedef struct packed {
		logic ck_clear;
		logic ck_xor;
		logic len_load;
		logic cnt_clear;
		logic cmd_load;
		logic store_wr;
		logic out_bad;
		logic out_zero;
		logic emit_start;
		logic emit;
	} mfp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_start;
		logic is_m;
		logic is_lt;
		logic len_ok;
		logic len_zero;
		logic data_done;
		logic csum_ok;
		logic emit_last;
		logic out_free;
	} mfp_sts_t;

endpackage

[hw/rtl/mfp_ctrl.sv]
module mfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mfp_pkg::mfp_sts_t sts,
	output mfp_pkg::mfp_cmd_t cmd
);
	import mfp_pkg::*;

	mfp_state_t state_q, state_d;
	logic       in_fire;

	assign in_stall = (state_q == ST_EMIT) || ((state_q == ST_CSUM) && !sts.out_free);
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_START: begin
				if (in_fire) state_d = sts.is_start ? ST_M : ST_START;
			end
			ST_M: begin
				if (in_fire) state_d = sts.is_m ? ST_ARROW : ST_START;
			end
			ST_ARROW: begin
				if (in_fire) state_d = sts.is_lt ? ST_LEN : ST_START;
			end
			ST_LEN: begin
				if (in_fire) state_d = sts.len_ok ? ST_CMD : ST_START;
			end
			ST_CMD: begin
				if (in_fire) state_d = sts.len_zero ? ST_CSUM : ST_DATA;
			end
			ST_DATA: begin
				if (in_fire && sts.data_done) state_d = ST_CSUM;
			end
			ST_CSUM: begin
				if (in_fire) begin
					state_d = (sts.csum_ok && !sts.len_zero) ? ST_EMIT : ST_START;
				end
			end
			ST_EMIT: begin
				if (sts.out_free && sts.emit_last) state_d = ST_START;
			end
			default: state_d = ST_START;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_ARROW: begin
				cmd.ck_clear = in_fire && sts.is_lt;
			end
			ST_LEN: begin
				cmd.len_load  = in_fire && sts.len_ok;
				cmd.cnt_clear = in_fire && sts.len_ok;
				cmd.ck_xor    = in_fire && sts.len_ok;
			end
			ST_CMD: begin
				cmd.cmd_load = in_fire;
				cmd.ck_xor   = in_fire;
			end
			ST_DATA: begin
				cmd.ck_xor   = in_fire;
				cmd.store_wr = in_fire;
			end
			ST_CSUM: begin
				cmd.out_bad    = in_fire && !sts.csum_ok;
				cmd.out_zero   = in_fire && sts.csum_ok && sts.len_zero;
				cmd.emit_start = in_fire && sts.csum_ok && !sts.len_zero;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> in_stall)
		else $error("input accepted during emission");
	a_emit_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_start |=> (state_q == ST_EMIT))
		else $error("emission did not begin");
	a_single_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.out_bad, cmd.out_zero, cmd.emit}) <= 1)
		else $error("conflicting output loads");
`endif

endmodule

[hw/rtl/mfp_datapath.sv]
module mfp_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 rx_byte,
	input  logic [mfp_pkg::LEN_W-1:0]  max_len,
	input  mfp_pkg::mfp_cmd_t          cmd,
	output mfp_pkg::mfp_sts_t          sts,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [7:0]                 command_code,
	output logic [6:0]                 payload_length,
	output logic [5:0]                 payload_index,
	output logic [7:0]                 payload_byte,
	output logic                       payload_valid,
	output logic                       last
);
	import mfp_pkg::*;

	logic [7:0]       ck_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       cmd_q;
	logic [LEN_W-1:0] cnt_q;
	logic [IDX_W-1:0] emit_idx_q;
	logic [7:0]       mem [MAX_PAYLOAD];
	logic [7:0]       rd_q;

	logic             out_valid_q;
	logic             status_q;
	logic [7:0]       ocmd_q;
	logic [LEN_W-1:0] olen_q;
	logic [IDX_W-1:0] oidx_q;
	logic             opvalid_q;
	logic             olast_q;

	logic [LEN_W:0]   cnt_next;
	logic [LEN_W:0]   emit_next;
	logic             out_load;

	assign cnt_next  = {1'b0, cnt_q} + 1'b1;
	assign emit_next = {{(LEN_W + 1 - IDX_W){1'b0}}, emit_idx_q} + 1'b1;
	assign out_load  = cmd.out_bad || cmd.out_zero || cmd.emit;

	assign sts.is_start  = (rx_byte == SYM_START);
	assign sts.is_m      = (rx_byte == SYM_M);
	assign sts.is_lt     = (rx_byte == SYM_LT);
	assign sts.len_ok    = (rx_byte <= {1'b0, max_len}) && (rx_byte <= 8'(MAX_PAYLOAD));
	assign sts.len_zero  = (len_q == '0);
	assign sts.data_done = (cnt_next >= {1'b0, len_q});
	assign sts.csum_ok   = (ck_q == rx_byte);
	assign sts.emit_last = (emit_next == {1'b0, len_q});
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_q       <= '0;
			len_q      <= '0;
			cmd_q      <= '0;
			cnt_q      <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.ck_clear) ck_q <= '0;
			else if (cmd.ck_xor) ck_q <= ck_q ^ rx_byte;
			if (cmd.ck_clear) len_q <= '0;
			else if (cmd.len_load) len_q <= rx_byte[LEN_W-1:0];
			if (cmd.cmd_load) cmd_q <= rx_byte;
			if (cmd.cnt_clear) cnt_q <= '0;
			else if (cmd.store_wr) cnt_q <= cnt_next[LEN_W-1:0];
			if (cmd.emit_start) emit_idx_q <= '0;
			else if (cmd.emit) emit_idx_q <= emit_next[IDX_W-1:0];
		end
	end

	// payload store, read one entry per emitted word
	always_ff @(posedge clk) begin
		if (cmd.store_wr) mem[cnt_q[IDX_W-1:0]] <= rx_byte;
		if (cmd.emit) rd_q <= mem[emit_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= cmd.out_bad;
			ocmd_q    <= cmd_q;
			olen_q    <= len_q;
			oidx_q    <= cmd.emit ? emit_idx_q : '0;
			opvalid_q <= cmd.emit;
			olast_q   <= cmd.emit ? sts.emit_last : 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign command_code   = ocmd_q;
	assign payload_length = olen_q;
	assign payload_index  = oidx_q;
	assign payload_byte   = opvalid_q ? rd_q : 8'h00;
	assign payload_valid  = opvalid_q;
	assign last           = olast_q;

`ifndef SYNTHESIS
	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_wr |-> (cnt_q < len_q))
		else $error("payload write beyond frame length");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ({1'b0, emit_idx_q} < {1'b0, len_q}))
		else $error("payload read beyond frame length");
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> sts.out_free)
		else $error("output register overwritten while stalled");
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.emit_last) |=> (out_valid_q && olast_q))
		else $error("final word not marked last");
`endif

endmodule

[hw/rtl/msp_command_frame_parser.sv]
// MSP request frame parser.
// Input channel: one received byte (rx_byte) per word, in_valid / in_stall.
// Output channel: one result word per payload byte of a good frame, or one
// word for a zero-length or bad-checksum frame, out_valid / out_stall.
// APB port: register 0 (byte address 0) holds max_payload_length, reset 64.
// Header, length, command and payload bytes are taken one per cycle; they
// produce no output. The checksum byte is taken when the output register is
// free; a bad or zero-length frame loads its word at that edge, so it
// appears in the following cycle. A good frame with N payload bytes then
// reads the payload memory, one entry and one output word per cycle while
// the output is not stalled (set by the single read port of the payload
// memory), N words, the input held stalled; the first word is loaded
// into the output register once the controller is in its emit state. The
// input takes one byte per cycle outside emission, when not stalled.
// A stall on the output holds the output register; emission and, on the
// checksum byte, input acceptance wait for it.
// Reset returns the parser to hunting for '$' and drops any pending word;
// the payload memory is not cleared.
module msp_command_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  command_code,
	output logic [6:0]  payload_length,
	output logic [5:0]  payload_index,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic        last
);
	import mfp_pkg::*;

	logic [LEN_W-1:0] max_len_q;
	mfp_cmd_t         cmd;
	mfp_sts_t         sts;
	logic             reg0_sel;

	assign pready   = 1'b1;
	assign reg0_sel = (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (psel && penable && pwrite && reg0_sel) begin
			max_len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = reg0_sel ? {{(32 - LEN_W){1'b0}}, max_len_q} : 32'h0;

	mfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfp_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx_byte),
		.max_len        (max_len_q),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.command_code   (command_code),
		.payload_length (payload_length),
		.payload_index  (payload_index),
		.payload_byte   (payload_byte),
		.payload_valid  (payload_valid),
		.last           (last)
	);

endmodule
